FILE: src/tmt_pkg.sv
// Shared declarations for the transaction match table: sizes, command codes,
// controller states and the layout of one table entry.
// No dependencies; every other file of the block imports this package.
package tmt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int REQ_DATA_W = 144;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 1;

   localparam logic [7:0] REPLY_MAX = 8'hFF;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_REPLY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] xid;
      logic [15:0] conversation;
      logic [31:0] prog;
      logic [31:0] version;
      logic [31:0] procedure;
      logic [7:0]  replies;
   } entry_type;

endpackage

FILE: src/transaction_match_table_core.sv
// Transaction match table top level: request/response streams, the entry
// memory and the controller that scans, updates and replaces entries.
// Depends on tmt_pkg.

// The block keeps up to TABLE_DEPTH outstanding calls in one synchronous
// memory, keyed by transaction id and conversation id. One request is
// processed at a time. A record or reply request walks the filled entries
// from the newest one backwards, one memory read per cycle, and stops
// early on a hit. A clear request, an unused command code or any request
// against an empty table skips the walk and goes straight to ST_FINISH.
// Each request yields exactly one response. The response sits in an output
// register, so a new request is taken while the previous response still
// waits; a finished request waits for that register to free up. The table
// needs no initialization after reset.
module transaction_match_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] transaction_id, [47:32] conversation_id, [79:48] program_number,
   // [111:80] program_version, [143:112] procedure_number
   input  logic [tmt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [tmt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] match_program, [63:32] match_version, [95:64] match_procedure,
   // [103:96] reply_count
   output logic [tmt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] found
   output logic [tmt_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tmt_pkg::*;

   entry_type           table_mem [TABLE_DEPTH];
   entry_type           mem_q;
   logic                rd_en;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   entry_type           wr_data;

   state_type           state_ff, state_in;
   command_type         cmd_ff, cmd_in;
   logic [31:0]         xid_ff, xid_in;
   logic [15:0]         conv_ff, conv_in;
   logic [31:0]         prog_ff, prog_in;
   logic [31:0]         vers_ff, vers_in;
   logic [31:0]         proc_ff, proc_in;

   logic [SLOT_W-1:0]   newest_ff, newest_in;
   logic [COUNT_W-1:0]  filled_ff, filled_in;
   logic [SLOT_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [COUNT_W-1:0]  issued_ff, issued_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [SLOT_W-1:0]   rd_slot_ff, rd_slot_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   hit_slot_ff, hit_slot_in;
   entry_type           hit_entry_ff, hit_entry_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                key_match;
   logic                rsp_free;
   logic [7:0]          next_replies;

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q <= table_mem[scan_addr_ff];
      end
   end

   assign key_match = rd_valid_ff && (mem_q.xid == xid_ff) && (mem_q.conversation == conv_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign next_replies = (hit_entry_ff.replies == REPLY_MAX) ? REPLY_MAX
                                                             : hit_entry_ff.replies + 8'd1;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      xid_in       = xid_ff;
      conv_in      = conv_ff;
      prog_in      = prog_ff;
      vers_in      = vers_ff;
      proc_in      = proc_ff;
      newest_in    = newest_ff;
      filled_in    = filled_ff;
      scan_addr_in = scan_addr_ff;
      issued_in    = issued_ff;
      rd_valid_in  = 1'b0;
      rd_slot_in   = rd_slot_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_entry_in = hit_entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = hit_slot_ff;
      wr_data      = hit_entry_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = command_type'(req_tuser[1:0]);
               xid_in       = req_tdata[31:0];
               conv_in      = req_tdata[47:32];
               prog_in      = req_tdata[79:48];
               vers_in      = req_tdata[111:80];
               proc_in      = req_tdata[143:112];
               hit_in       = 1'b0;
               scan_addr_in = newest_ff;
               issued_in    = '0;
               if ((cmd_in == CMD_RECORD || cmd_in == CMD_REPLY) && filled_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            if (key_match) begin
               hit_in       = 1'b1;
               hit_slot_in  = rd_slot_ff;
               hit_entry_in = mem_q;
               state_in     = ST_FINISH;
            end else if (issued_ff == filled_ff) begin
               // The last filled entry was compared this cycle without a hit.
               state_in = ST_FINISH;
            end else begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_slot_in  = scan_addr_ff;
               issued_in   = issued_ff + COUNT_W'(1);
               // Walk backwards through the filled slots, wrapping at the top one.
               if (scan_addr_ff == '0) begin
                  scan_addr_in = SLOT_W'(filled_ff - COUNT_W'(1));
               end else begin
                  scan_addr_in = scan_addr_ff - SLOT_W'(1);
               end
            end
         end

         ST_FINISH: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_data_in  = '0;
               case (cmd_ff)
                  CMD_RECORD: begin
                     if (hit_ff) begin
                        rsp_found_in = 1'b1;
                        rsp_data_in  = {hit_entry_ff.replies, hit_entry_ff.procedure,
                                        hit_entry_ff.version, hit_entry_ff.prog};
                     end else begin
                        // Fill free slots in order, then replace the oldest entry.
                        if (filled_ff != COUNT_W'(TABLE_DEPTH)) begin
                           newest_in = SLOT_W'(filled_ff);
                           filled_in = filled_ff + COUNT_W'(1);
                        end else if (newest_ff == SLOT_W'(TABLE_DEPTH - 1)) begin
                           newest_in = '0;
                        end else begin
                           newest_in = newest_ff + SLOT_W'(1);
                        end
                        wr_en                = 1'b1;
                        wr_addr              = newest_in;
                        wr_data.xid          = xid_ff;
                        wr_data.conversation = conv_ff;
                        wr_data.prog         = prog_ff;
                        wr_data.version      = vers_ff;
                        wr_data.procedure    = proc_ff;
                        wr_data.replies      = '0;
                     end
                  end
                  CMD_REPLY: begin
                     if (hit_ff) begin
                        wr_en           = 1'b1;
                        wr_data.replies = next_replies;
                        rsp_found_in    = 1'b1;
                        rsp_data_in     = {next_replies, hit_entry_ff.procedure,
                                           hit_entry_ff.version, hit_entry_ff.prog};
                     end
                  end
                  CMD_CLEAR: begin
                     filled_in = '0;
                     newest_in = '0;
                  end
                  CMD_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= '0;
         filled_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         filled_ff    <= filled_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      xid_ff       <= xid_in;
      conv_ff      <= conv_in;
      prog_ff      <= prog_in;
      vers_ff      <= vers_in;
      proc_ff      <= proc_in;
      scan_addr_ff <= scan_addr_in;
      issued_ff    <= issued_in;
      rd_slot_ff   <= rd_slot_in;
      hit_slot_ff  <= hit_slot_in;
      hit_entry_ff <= hit_entry_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

FILE: src/tmt_checker.sv
// Port-level checks for the transaction match table core, and the bind that
// attaches them to transaction_match_table_core. Depends on tmt_pkg.
module tmt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [tmt_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [tmt_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tmt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [tmt_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tmt_pkg::*;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A response without a match carries only zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss response carries nonzero data");

   // Requests are processed one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in progress");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind transaction_match_table_core tmt_checker u_tmt_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for transaction_match_table_core: drives request
// streams with random stalls and checks each response against a predictor.
// Depends on tmt_pkg and the block's RTL.

typedef struct packed {
   logic        found;
   logic [31:0] prog;
   logic [31:0] vers;
   logic [31:0] proc_num;
   logic [7:0]  replies;
} lookup_result_type;

class match_table_checker;
   bit [31:0] tab_xid     [tmt_pkg::TABLE_DEPTH];
   bit [15:0] tab_conv    [tmt_pkg::TABLE_DEPTH];
   bit [31:0] tab_prog    [tmt_pkg::TABLE_DEPTH];
   bit [31:0] tab_vers    [tmt_pkg::TABLE_DEPTH];
   bit [31:0] tab_proc    [tmt_pkg::TABLE_DEPTH];
   bit [7:0]  tab_replies [tmt_pkg::TABLE_DEPTH];
   int unsigned newest;
   int unsigned filled;
   lookup_result_type pending_results[$];
   int errors;

   function new();
      newest = 0;
      filled = 0;
      errors = 0;
   endfunction

   // Walks the filled slots from the newest one backwards, as the block does.
   function int find_slot(bit [31:0] xid, bit [15:0] conv);
      int unsigned slot;
      if (filled == 0) return -1;
      slot = newest % filled;
      for (int unsigned n = 0; n < filled; n++) begin
         if (tab_xid[slot] == xid && tab_conv[slot] == conv) return int'(slot);
         slot = (slot + filled - 1) % filled;
      end
      return -1;
   endfunction

   function void note_request(tmt_pkg::command_type cmd, bit [31:0] xid, bit [15:0] conv,
                              bit [31:0] prog, bit [31:0] vers, bit [31:0] proc_num);
      lookup_result_type res;
      int hit;
      res = '0;
      case (cmd)
         tmt_pkg::CMD_RECORD, tmt_pkg::CMD_REPLY: begin
            hit = find_slot(xid, conv);
            if (hit >= 0) begin
               if (cmd == tmt_pkg::CMD_REPLY && tab_replies[hit] != tmt_pkg::REPLY_MAX)
                  tab_replies[hit] = tab_replies[hit] + 8'd1;
               res.found    = 1'b1;
               res.prog     = tab_prog[hit];
               res.vers     = tab_vers[hit];
               res.proc_num = tab_proc[hit];
               res.replies  = tab_replies[hit];
            end else if (cmd == tmt_pkg::CMD_RECORD) begin
               // Free slots fill in order; a full table replaces the oldest entry.
               if (filled < tmt_pkg::TABLE_DEPTH) begin
                  newest = filled;
                  filled++;
               end else begin
                  newest = (newest + 1) % tmt_pkg::TABLE_DEPTH;
               end
               tab_xid[newest]     = xid;
               tab_conv[newest]    = conv;
               tab_prog[newest]    = prog;
               tab_vers[newest]    = vers;
               tab_proc[newest]    = proc_num;
               tab_replies[newest] = 8'd0;
            end
         end
         tmt_pkg::CMD_CLEAR: begin
            filled = 0;
            newest = 0;
         end
         default: ;
      endcase
      pending_results.push_back(res);
   endfunction

   function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         errors++;
      end
   endfunction

   function void check_response(lookup_result_type got);
      lookup_result_type exp_res;
      if (pending_results.size() == 0) begin
         $display("%0t: response with no request outstanding, expected none, actual %h",
                  $time, got);
         errors++;
         return;
      end
      exp_res = pending_results.pop_front();
      compare_field("found", 32'(exp_res.found), 32'(got.found));
      compare_field("match_program", exp_res.prog, got.prog);
      compare_field("match_version", exp_res.vers, got.vers);
      compare_field("match_procedure", exp_res.proc_num, got.proc_num);
      compare_field("reply_count", 32'(exp_res.replies), 32'(got.replies));
   endfunction
endclass

module testbench;
   import tmt_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [31:0] transaction_id, [47:32] conversation_id, [79:48] program_number,
   // [111:80] program_version, [143:112] procedure_number
   logic [REQ_DATA_W-1:0] req_tdata;
   // [1:0] command
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [31:0] match_program, [63:32] match_version, [95:64] match_procedure,
   // [103:96] reply_count
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] found
   logic [RSP_USER_W-1:0] rsp_tuser;

   match_table_checker table_model;
   bit                 idling_on;
   int                 stall_left;
   // Keys of recorded calls, transaction id in the upper 32 bits.
   bit [47:0]          key_pool[$];

   transaction_match_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      idling_on  = 1'b1;
      stall_left = 0;
      table_model = new();
   end

   always #6 clock = ~clock;

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            table_model.note_request(command_type'(req_tuser), req_tdata[31:0],
                                     req_tdata[47:32], req_tdata[79:48],
                                     req_tdata[111:80], req_tdata[143:112]);
         if (rsp_tvalid && rsp_tready)
            table_model.check_response(lookup_result_type'({rsp_tuser[0], rsp_tdata[31:0],
                                       rsp_tdata[63:32], rsp_tdata[95:64],
                                       rsp_tdata[103:96]}));
      end
   end

   // Response side: bursts of back-pressure while idling is on.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Entered and left just after a falling edge.
   task automatic issue(input command_type cmd, input bit [47:0] key, input bit [31:0] prog,
                        input bit [31:0] vers, input bit [31:0] proc_num);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {proc_num, vers, prog, key[15:0], key[47:16]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic bit [47:0] fresh_key();
      bit [47:0] key;
      key[47:16] = $urandom;
      key[15:0]  = 16'($urandom_range(0, 65535));
      return key;
   endfunction

   function automatic bit [47:0] pool_key();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   // Keys mostly drawn from those already recorded, so that duplicates and reply hits are common.
   task automatic random_request(input int clear_pct);
      int        roll;
      int        pick;
      bit [47:0] key;
      bit        fresh;
      roll  = $urandom_range(0, 99);
      pick  = $urandom_range(0, 9);
      key   = fresh_key();
      fresh = 1'b1;
      if (key_pool.size() != 0 && pick >= 4) begin
         key   = pool_key();
         fresh = 1'b0;
         // A near miss: same transaction id on another conversation.
         if (pick >= 8) key[15:0] = key[15:0] ^ (16'h1 << $urandom_range(0, 15));
      end
      if (roll < clear_pct) begin
         issue(CMD_CLEAR, key, $urandom, $urandom, $urandom);
         key_pool.delete();
      end else if (roll < clear_pct + 3) begin
         issue(CMD_NONE, key, $urandom, $urandom, $urandom);
      end else if (roll < 50) begin
         issue(CMD_RECORD, key, $urandom, $urandom, $urandom);
         if (fresh) key_pool.push_back(key);
         if (key_pool.size() > 512) void'(key_pool.pop_front());
      end else begin
         issue(CMD_REPLY, key, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin : stimulus
      bit [47:0] key;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, field extremes, duplicates, misses, clear.
      issue(CMD_REPLY,  48'h0, 32'h0, 32'h0, 32'h0);
      issue(CMD_RECORD, 48'h0, 32'h0, 32'h0, 32'h0);
      issue(CMD_RECORD, {48{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(CMD_RECORD, 48'h0, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
      issue(CMD_REPLY,  {48{1'b1}}, 32'h0, 32'h0, 32'h0);
      issue(CMD_REPLY,  {48{1'b1}}, 32'h0, 32'h0, 32'h0);
      issue(CMD_REPLY,  {32'hFFFF_FFFF, 16'h0}, 32'h0, 32'h0, 32'h0);
      issue(CMD_REPLY,  {32'h0, 16'hFFFF}, 32'h0, 32'h0, 32'h0);
      issue(CMD_RECORD, {48{1'b1}}, 32'h0, 32'h0, 32'h0);
      issue(CMD_NONE,   {48{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(CMD_REPLY,  48'h0, 32'h0, 32'h0, 32'h0);
      issue(CMD_RECORD, {32'h1234_5678, 16'h1234}, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
            32'h0F0F_0F0F);
      issue(CMD_REPLY,  {32'h1234_5678, 16'h1234}, 32'h0, 32'h0, 32'h0);
      issue(CMD_CLEAR,  {48{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(CMD_REPLY,  48'h0, 32'h0, 32'h0, 32'h0);
      issue(CMD_RECORD, 48'h0, 32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000);
      issue(CMD_REPLY,  48'h0, 32'h0, 32'h0, 32'h0);
      issue(CMD_NONE,   48'h0, 32'h0, 32'h0, 32'h0);
      issue(CMD_CLEAR,  48'h0, 32'h0, 32'h0, 32'h0);

      repeat (750) random_request(2);

      // Drive one entry's reply count into saturation.
      key = fresh_key();
      issue(CMD_RECORD, key, $urandom, $urandom, $urandom);
      repeat (258) issue(CMD_REPLY, key, $urandom, $urandom, $urandom);

      // Fill past capacity so the oldest entries get replaced, then probe.
      issue(CMD_CLEAR, fresh_key(), $urandom, $urandom, $urandom);
      key_pool.delete();
      repeat (300) begin
         key = fresh_key();
         issue(CMD_RECORD, key, $urandom, $urandom, $urandom);
         key_pool.push_back(key);
      end
      repeat (120) issue(CMD_REPLY, pool_key(), $urandom, $urandom, $urandom);

      idling_on = 1'b0;
      repeat (300) random_request(1);
      req_tvalid <= 1'b0;

      while (table_model.pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (table_model.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
